// ===== hdl/lad_pkg.sv =====
// ----------------------------------------------------------------------------
// lad_pkg
// Shared types and codes for the linear array deque.
// ----------------------------------------------------------------------------
package lad_pkg;

  localparam int unsigned DataWidth = 32;

  typedef enum logic [1:0] {
    OP_PUSH_REAR  = 2'd0,
    OP_POP_FRONT  = 2'd1,
    OP_PUSH_FRONT = 2'd2,
    OP_POP_REAR   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_NO_FRONT  = 2'd3
  } status_e;

  typedef struct packed {
    logic capture;
    logic execute;
  } lad_cmd_t;

endpackage

// ===== hdl/lad_datapath.sv =====
// ----------------------------------------------------------------------------
// lad_datapath
// Slot memory, front/rear indices, empty mark and result register.
// ----------------------------------------------------------------------------
module lad_datapath #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lad_pkg::lad_cmd_t           cmd_i,
  input  logic [1:0]                  opcode_i,
  input  logic [lad_pkg::DataWidth-1:0] push_value_i,
  output logic [1:0]                  status_o,
  output logic [lad_pkg::DataWidth-1:0] popped_value_o
);
  import lad_pkg::*;

  localparam int unsigned IdxWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [IdxWidth-1:0] LastIdx = IdxWidth'(DEPTH - 1);

  logic [DataWidth-1:0] mem_q [DEPTH];
  logic [DataWidth-1:0] rd_data_q;
  logic [IdxWidth-1:0]  rd_addr;

  op_e                  op_q;
  logic [DataWidth-1:0] value_q;

  logic [IdxWidth-1:0]  head_q, head_d;
  logic [IdxWidth-1:0]  tail_q, tail_d;
  logic                 empty_q, empty_d;

  logic                 wr_en;
  logic [IdxWidth-1:0]  wr_addr;

  status_e              status_d, status_q;
  logic [DataWidth-1:0] popped_d, popped_q;

  assign rd_addr = (op_e'(opcode_i) == OP_POP_FRONT) ? head_q : tail_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      rd_data_q <= mem_q[rd_addr];
      op_q      <= op_e'(opcode_i);
      value_q   <= push_value_i;
    end
    if (wr_en) begin
      mem_q[wr_addr] <= value_q;
    end
    if (cmd_i.execute) begin
      status_q <= status_d;
      popped_q <= popped_d;
    end
  end

  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    empty_d  = empty_q;
    wr_en    = 1'b0;
    wr_addr  = tail_q;
    status_d = ST_OK;
    popped_d = '0;
    unique case (op_q)
      OP_PUSH_REAR: begin
        if (empty_q) begin
          head_d  = '0;
          tail_d  = '0;
          empty_d = 1'b0;
          wr_en   = 1'b1;
          wr_addr = '0;
        end else if (tail_q == LastIdx) begin
          status_d = ST_OVERFLOW;
        end else begin
          tail_d  = tail_q + 1'b1;
          wr_en   = 1'b1;
          wr_addr = tail_q + 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (empty_q) begin
          status_d = ST_UNDERFLOW;
        end else begin
          popped_d = rd_data_q;
          if (head_q >= tail_q) begin
            head_d  = '0;
            tail_d  = '0;
            empty_d = 1'b1;
          end else begin
            head_d = head_q + 1'b1;
          end
        end
      end
      OP_PUSH_FRONT: begin
        if (empty_q || head_q == '0) begin
          status_d = ST_NO_FRONT;
        end else begin
          head_d  = head_q - 1'b1;
          wr_en   = 1'b1;
          wr_addr = head_q - 1'b1;
        end
      end
      OP_POP_REAR: begin
        if (empty_q) begin
          status_d = ST_UNDERFLOW;
        end else begin
          popped_d = rd_data_q;
          if (tail_q <= head_q) begin
            head_d  = '0;
            tail_d  = '0;
            empty_d = 1'b1;
          end else begin
            tail_d = tail_q - 1'b1;
          end
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
    if (!cmd_i.execute) begin
      wr_en   = 1'b0;
      head_d  = head_q;
      tail_d  = tail_q;
      empty_d = empty_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      empty_q <= 1'b1;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      empty_q <= empty_d;
    end
  end

  assign status_o       = status_q;
  assign popped_value_o = popped_q;

endmodule

// ===== hdl/lad_controller.sv =====
// ----------------------------------------------------------------------------
// lad_controller
// Sequences one word at a time: accept, execute, deliver.
// ----------------------------------------------------------------------------
module lad_controller (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output lad_pkg::lad_cmd_t cmd_o
);
  import lad_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_OUT
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign cmd_o.capture = in_ready_o && in_valid_i;
  assign cmd_o.execute = (state_q == S_EXEC);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_q     <= S_OUT;
          out_valid_q <= 1'b1;
        end
        S_OUT: begin
          if (out_ready_i) begin
            state_q     <= S_IDLE;
            out_valid_q <= 1'b0;
          end
        end
        default: begin
          state_q     <= S_IDLE;
          out_valid_q <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ===== hdl/linear_array_deque_core.sv =====
// ----------------------------------------------------------------------------
// linear_array_deque_core
// Double-ended queue in a fixed, non-wrapping slot memory.
// ----------------------------------------------------------------------------
// Sequence: capture with slot read in S_IDLE, execute with index update and
//   result register in S_EXEC, and the output handshake in S_OUT, where a
//   sink that is not ready holds the word. A new input word is accepted only
//   after the output word has been taken.
// Reset: asynchronous; queue empty, both indices at 0, no output pending.
//   Slot contents are not cleared.
module linear_array_deque_core #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [lad_pkg::DataWidth-1:0] s_axis_tdata,  // [31:0] push_value
  input  logic [1:0]                    s_axis_tuser,  // [1:0] opcode
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [lad_pkg::DataWidth-1:0] m_axis_tdata,  // [31:0] popped_value
  output logic [1:0]                    m_axis_tuser   // [1:0] status
);
  import lad_pkg::*;

  lad_cmd_t cmd;

  lad_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  lad_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .opcode_i       (s_axis_tuser),
    .push_value_i   (s_axis_tdata),
    .status_o       (m_axis_tuser),
    .popped_value_o (m_axis_tdata)
  );

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for linear_array_deque_core. A scoreboard keeps its own
// copy of the deque, predicts status and popped data for every accepted
// input word and checks each output word in order. A short directed run hits
// the empty, full-rear and front-at-slot-0 corners. Random traffic follows,
// in alternating fill and drain phases, with random gaps on both streams.
// ----------------------------------------------------------------------------
module tb;
  import lad_pkg::*;

  localparam int unsigned Depth     = 16;
  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned NumRandom = 500;

  typedef struct packed {
    status_e     status;
    logic [31:0] value;
  } deque_result_t;

  class deque_scoreboard;
    logic [31:0]   slots [Depth];
    int unsigned   head;
    int unsigned   tail;
    bit            empty;
    deque_result_t expected_results[$];
    int unsigned   n_checked;
    int unsigned   n_errors;
    int unsigned   n_status [4];

    function new();
      head  = 0;
      tail  = 0;
      empty = 1'b1;
    endfunction

    function void note_op(op_e op, logic [31:0] val);
      deque_result_t res;
      res.status = ST_OK;
      res.value  = '0;
      case (op)
        OP_PUSH_REAR: begin
          if (empty) begin
            head     = 0;
            tail     = 0;
            slots[0] = val;
            empty    = 1'b0;
          end else if (tail >= Depth - 1) begin
            res.status = ST_OVERFLOW;
          end else begin
            tail        = tail + 1;
            slots[tail] = val;
          end
        end
        OP_POP_FRONT: begin
          if (empty) begin
            res.status = ST_UNDERFLOW;
          end else begin
            res.value = slots[head];
            if (head >= tail) begin
              head  = 0;
              tail  = 0;
              empty = 1'b1;
            end else begin
              head = head + 1;
            end
          end
        end
        OP_PUSH_FRONT: begin
          if (empty || head == 0) begin
            res.status = ST_NO_FRONT;
          end else begin
            head        = head - 1;
            slots[head] = val;
          end
        end
        default: begin
          if (empty) begin
            res.status = ST_UNDERFLOW;
          end else begin
            res.value = slots[tail];
            if (tail <= head) begin
              head  = 0;
              tail  = 0;
              empty = 1'b1;
            end else begin
              tail = tail - 1;
            end
          end
        end
      endcase
      n_status[res.status] = n_status[res.status] + 1;
      expected_results.push_back(res);
    endfunction

    function void check_word(status_e status, logic [31:0] value);
      deque_result_t exp_res;
      if (expected_results.size() == 0) begin
        n_errors = n_errors + 1;
        if (n_errors <= 10)
          $display("unexpected output word: status %s data %08h", status.name(), value);
        return;
      end
      exp_res   = expected_results.pop_front();
      n_checked = n_checked + 1;
      if (exp_res.status !== status || exp_res.value !== value) begin
        n_errors = n_errors + 1;
        if (n_errors <= 10)
          $display("word %0d mismatch: status exp %s got %s, data exp %08h got %08h",
                   n_checked, exp_res.status.name(), status.name(), exp_res.value, value);
      end
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction
  endclass

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        s_valid = 1'b0;
  logic [31:0] s_data  = '0;
  logic [1:0]  s_user  = '0;
  logic        m_ready = 1'b0;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  deque_scoreboard sb = new();
  bit              calm = 1'b0;
  int unsigned     idle_cycles = 0;
  int unsigned     sink_stall = 0;
  int unsigned     n_sent = 0;

  linear_array_deque_core #(
    .DEPTH(Depth)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_data),
    .s_axis_tuser (s_user),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #1 clk_i = ~clk_i;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_word(op_e op, logic [31:0] val);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= val;
    s_user  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_op(op, val);
    n_sent = n_sent + 1;
  endtask

  task automatic run_directed();
    send_word(OP_POP_FRONT, 32'hffff_ffff);
    send_word(OP_POP_REAR, 32'h0000_0000);
    send_word(OP_PUSH_FRONT, 32'h1234_5678);
    send_word(OP_PUSH_REAR, 32'h7fff_ffff);
    send_word(OP_PUSH_FRONT, 32'h5555_5555);
    send_word(OP_POP_REAR, 32'h0);
    send_word(OP_PUSH_REAR, 32'h8000_0000);
    for (int i = 1; i < Depth; i++)
      send_word(OP_PUSH_REAR, (i % 2) ? 32'hffff_ffff : 32'h0000_0000 + i);
    send_word(OP_PUSH_REAR, 32'haaaa_aaaa);
    send_word(OP_POP_FRONT, 32'h0);
    send_word(OP_PUSH_FRONT, 32'h7fff_ffff);
    send_word(OP_POP_FRONT, 32'h0);
  endtask

  task automatic run_random();
    bit          fill;
    int unsigned left_in_phase;
    int unsigned r;
    op_e         op;
    fill          = 1'b1;
    left_in_phase = $urandom_range(10, 40);
    for (int i = 0; i < NumRandom; i++) begin
      if (left_in_phase == 0) begin
        fill          = ~fill;
        left_in_phase = $urandom_range(10, 40);
        calm          = ($urandom_range(0, 3) == 0);
      end
      left_in_phase = left_in_phase - 1;
      r = $urandom_range(0, 99);
      if (fill)
        op = (r < 40) ? OP_PUSH_REAR : (r < 75) ? OP_PUSH_FRONT :
             (r < 88) ? OP_POP_FRONT : OP_POP_REAR;
      else
        op = (r < 12) ? OP_PUSH_REAR : (r < 25) ? OP_PUSH_FRONT :
             (r < 62) ? OP_POP_FRONT : OP_POP_REAR;
      send_word(op, pick_value());
    end
    calm = 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else if (sink_stall > 0) begin
      sink_stall = sink_stall - 1;
      m_ready <= 1'b0;
    end else begin
      m_ready <= 1'b1;
      sink_stall = pick_gap();
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_ready)
        sb.check_word(status_e'(m_axis_tuser), m_axis_tdata);
      if ((m_axis_tvalid && m_ready) || (s_valid && s_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("timeout: %0d words still expected", sb.pending());
        $display("[linear_array_deque_core] ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    run_random();
    s_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("sent %0d ops, checked %0d words, %0d mismatches", n_sent, sb.n_checked,
             sb.n_errors);
    $display("status mix: ok %0d, rear overflow %0d, empty underflow %0d, no front %0d",
             sb.n_status[ST_OK], sb.n_status[ST_OVERFLOW], sb.n_status[ST_UNDERFLOW],
             sb.n_status[ST_NO_FRONT]);
    if (sb.n_errors == 0 && sb.pending() == 0)
      $display("[linear_array_deque_core] OK");
    else
      $display("[linear_array_deque_core] ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/lad_pkg.sv
hdl/lad_datapath.sv
hdl/lad_controller.sv
hdl/linear_array_deque_core.sv
tb/sv/tb.sv
